// ===== design/brmr_pkg.sv =====
// Shared types and codes for the batched result min reducer.
// Used by batched_result_min_reducer_unit; no dependencies.
package brmr_pkg;

  // request codes on req_type
  localparam logic [1:0] REQ_ARRIVAL = 2'd0;
  localparam logic [1:0] REQ_FLUSH   = 2'd1;
  localparam logic [1:0] REQ_RESULT  = 2'd2;

  // result kinds on out_kind
  localparam logic OUT_ID      = 1'b0;
  localparam logic OUT_PUBLISH = 1'b1;

  localparam int          CNT_SAT_W = 5;
  localparam logic [4:0]  CNT_SAT   = 5'd31;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RMW  = 3'b010,
    ST_PUB  = 3'b100
  } state_t;

endpackage

// ===== design/batched_result_min_reducer_unit.sv =====
// Batched result min reducer: batch ring control, slot stores and publish sequencer.
// Depends on brmr_pkg (request codes, result kinds, state type).
//
// Arrivals and flushes are handled in the idle state without raising busy; a
// partial result element raises busy for the read-modify-write of the slot
// priority store, whose read is registered. When an element completes a batch,
// publishing reads each valid slot in turn and then drains the last store read,
// and busy stays high until that drain is done. Each result is registered onto
// done from the accepted request or the store read data; the receiver cannot stall,
// so every done pulse must be captured. There is no clearing pass after reset: the
// user must read slot stores only where written; the block does not enforce it.
module batched_result_min_reducer_unit #(
  parameter int BATCH_SLOTS = 16,
  parameter int RING_DEPTH  = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  req_type,
  input  logic [2:0]  batch_index,
  input  logic [3:0]  slot_index,
  input  logic [31:0] result_priority,
  input  logic [31:0] result_action,
  input  logic        contribution_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [4:0]  cfg_data,
  output logic        done,
  output logic        out_kind,
  output logic [31:0] pkt_id,
  output logic        batch_closed,
  output logic [2:0]  closed_batch,
  output logic [31:0] merged_priority,
  output logic [31:0] merged_action,
  output logic        last_of_run
);

  localparam int SLOT_W    = (BATCH_SLOTS > 1) ? $clog2(BATCH_SLOTS) : 1;
  localparam int RING_W    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BATCH_SLOTS + 1);
  localparam int ADDR_W    = RING_W + SLOT_W;
  localparam int MEM_DEPTH = 1 << ADDR_W;

  brmr_pkg::state_t state;

  logic [4:0]        engine_count;
  logic [31:0]       id_counter;
  logic [RING_W-1:0] ring_ptr;
  logic [CNT_W-1:0]  fill_count;
  logic [brmr_pkg::CNT_SAT_W-1:0] contributions_seen [RING_DEPTH];
  logic [CNT_W-1:0]  valid_slots [RING_DEPTH];

  // slot stores
  logic [31:0] id_mem  [MEM_DEPTH];
  logic [31:0] pri_mem [MEM_DEPTH];
  logic [31:0] act_mem [MEM_DEPTH];
  logic [31:0] id_rd, pri_rd, act_rd;
  logic [ADDR_W-1:0] rd_addr;

  // held result element
  logic [RING_W-1:0] h_batch;
  logic [SLOT_W-1:0] h_slot;
  logic              h_slot_ok;
  logic [31:0]       h_pri;
  logic [31:0]       h_act;
  logic              h_cend;

  // publish sequencer
  logic [RING_W-1:0] pub_batch;
  logic [CNT_W-1:0]  pub_idx;
  logic [CNT_W-1:0]  pub_cnt;
  logic              pub_last;
  logic              rd_pend;
  logic              rd_last;

  logic accept;
  logic is_id_req;
  logic batch_ok;
  logic closes;
  logic [CNT_W-1:0] fill_next;
  logic [brmr_pkg::CNT_SAT_W-1:0] cs_cur;
  logic [brmr_pkg::CNT_SAT_W-1:0] cs_next;
  logic first_contrib;
  logic take_new;
  logic do_publish;
  logic [RING_W-1:0] ptr_next;

  assign busy      = (state != brmr_pkg::ST_IDLE) || rd_pend;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign is_id_req = (req_type == brmr_pkg::REQ_ARRIVAL) || (req_type == brmr_pkg::REQ_FLUSH);
  assign batch_ok  = 32'(batch_index) < RING_DEPTH;
  assign fill_next = fill_count + CNT_W'(1);
  assign closes    = (req_type == brmr_pkg::REQ_FLUSH) || (32'(fill_next) == BATCH_SLOTS);
  assign ptr_next  = (ring_ptr == RING_W'(RING_DEPTH - 1)) ? '0 : ring_ptr + RING_W'(1);

  assign cs_cur        = contributions_seen[h_batch];
  assign first_contrib = (cs_cur == '0);
  assign cs_next       = (h_cend && cs_cur < brmr_pkg::CNT_SAT) ?
                         cs_cur + brmr_pkg::CNT_SAT_W'(1) : cs_cur;
  assign take_new      = h_slot_ok && (first_contrib || h_pri < pri_rd);
  assign do_publish    = h_cend && (cs_next == engine_count) && (valid_slots[h_batch] != '0);

  assign pub_last = (pub_idx + CNT_W'(1)) == pub_cnt;

  always_comb begin
    if (state == brmr_pkg::ST_PUB) begin
      rd_addr = {pub_batch, pub_idx[SLOT_W-1:0]};
    end else begin
      rd_addr = {RING_W'(batch_index), SLOT_W'(slot_index)};
    end
  end

  // slot stores: one write and one registered read per cycle each
  always_ff @(posedge clk) begin
    if (state == brmr_pkg::ST_IDLE && accept && is_id_req) begin
      id_mem[{ring_ptr, fill_count[SLOT_W-1:0]}] <= id_counter;
    end
    if (state == brmr_pkg::ST_RMW && take_new) begin
      pri_mem[{h_batch, h_slot}] <= h_pri;
      act_mem[{h_batch, h_slot}] <= h_act;
    end
    id_rd  <= id_mem[rd_addr];
    pri_rd <= pri_mem[rd_addr];
    act_rd <= act_mem[rd_addr];
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= brmr_pkg::ST_IDLE;
      engine_count <= 5'd1;
      id_counter   <= '0;
      ring_ptr     <= '0;
      fill_count   <= '0;
      done         <= 1'b0;
      rd_pend      <= 1'b0;
      rd_last      <= 1'b0;
      pub_idx      <= '0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        contributions_seen[i] <= '0;
        valid_slots[i]        <= '0;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        engine_count <= cfg_data;
      end
      // id requests answer next cycle; publish reads answer after the store read
      done    <= rd_pend || (accept && is_id_req);
      rd_pend <= (state == brmr_pkg::ST_PUB);
      unique case (state)
        brmr_pkg::ST_IDLE: begin
          if (accept) begin
            case (req_type) inside
              brmr_pkg::REQ_ARRIVAL, brmr_pkg::REQ_FLUSH: begin
                id_counter <= id_counter + 32'd1;
                if (closes) begin
                  // flush leaves the tail slots unpublished via valid_slots
                  valid_slots[ring_ptr] <= (req_type == brmr_pkg::REQ_ARRIVAL) ?
                                           fill_next : fill_count;
                  contributions_seen[ring_ptr] <= '0;
                  ring_ptr   <= ptr_next;
                  fill_count <= '0;
                end else begin
                  fill_count <= fill_next;
                end
              end
              brmr_pkg::REQ_RESULT: begin
                if (batch_ok) begin
                  state <= brmr_pkg::ST_RMW;
                end
              end
              default: ;
            endcase
          end
        end
        brmr_pkg::ST_RMW: begin
          contributions_seen[h_batch] <= cs_next;
          pub_idx <= '0;
          state   <= do_publish ? brmr_pkg::ST_PUB : brmr_pkg::ST_IDLE;
        end
        brmr_pkg::ST_PUB: begin
          rd_last <= pub_last;
          pub_idx <= pub_idx + CNT_W'(1);
          if (pub_last) begin
            state <= brmr_pkg::ST_IDLE;
          end
        end
        default: state <= brmr_pkg::ST_IDLE;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state == brmr_pkg::ST_IDLE && accept) begin
      h_batch   <= RING_W'(batch_index);
      h_slot    <= SLOT_W'(slot_index);
      h_slot_ok <= 32'(slot_index) < BATCH_SLOTS;
      h_pri     <= result_priority;
      h_act     <= result_action;
      h_cend    <= contribution_end;
    end
    if (state == brmr_pkg::ST_RMW) begin
      pub_batch <= h_batch;
      pub_cnt   <= valid_slots[h_batch];
    end
    if (rd_pend) begin
      out_kind        <= brmr_pkg::OUT_PUBLISH;
      pkt_id          <= id_rd;
      batch_closed    <= 1'b0;
      closed_batch    <= '0;
      merged_priority <= pri_rd;
      merged_action   <= act_rd;
      last_of_run     <= rd_last;
    end else if (state == brmr_pkg::ST_IDLE && accept && is_id_req) begin
      out_kind        <= brmr_pkg::OUT_ID;
      pkt_id          <= id_counter;
      batch_closed    <= closes;
      closed_batch    <= closes ? 3'(ring_ptr) : 3'd0;
      merged_priority <= '0;
      merged_action   <= '0;
      last_of_run     <= 1'b0;
    end
  end

  // a published result comes only from a store read whose data was pending (rd_pend) the cycle before
  a_pub_from_read: assert property (@(posedge clk) disable iff (rst)
    done && out_kind |-> $past(rd_pend))
    else $error("published result without store read");

  a_pub_idx_range: assert property (@(posedge clk) disable iff (rst)
    state == brmr_pkg::ST_PUB |-> pub_idx < pub_cnt)
    else $error("publish index past valid slot count");

  a_last_only_pub: assert property (@(posedge clk) disable iff (rst)
    done && last_of_run |-> out_kind == brmr_pkg::OUT_PUBLISH)
    else $error("last_of_run on id result");

  a_fill_below_full: assert property (@(posedge clk) disable iff (rst)
    32'(fill_count) < BATCH_SLOTS)
    else $error("fill count reached batch size without close");

  a_result_to_rmw: assert property (@(posedge clk) disable iff (rst)
    accept && req_type == brmr_pkg::REQ_RESULT && batch_ok |=> state == brmr_pkg::ST_RMW)
    else $error("result element did not enter read-modify-write");

endmodule

// ===== tb/tb_batched_result_min_reducer_unit.sv =====
// Testbench for batched_result_min_reducer_unit: directed and random request streams,
// with results checked in order against a behavioral copy of the batch ring.
// Depends on brmr_pkg (request codes, result kinds, count saturation value).
module tb_batched_result_min_reducer_unit;

  localparam int SLOTS        = 16;
  localparam int RING         = 8;
  localparam int DRAIN_CYCLES = 24;
  localparam int QUIET_LIMIT  = 1000;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]  rtype;
    logic [2:0]  bidx;
    logic [3:0]  sidx;
    logic [31:0] prio;
    logic [31:0] act;
    logic        cend;
  } reduce_req_t;

  typedef struct packed {
    logic        kind;
    logic [31:0] id;
    logic        closed;
    logic [2:0]  which;
    logic [31:0] prio;
    logic [31:0] act;
    logic        last;
  } reduce_out_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  req_type = '0;
  logic [2:0]  batch_index = '0;
  logic [3:0]  slot_index = '0;
  logic [31:0] result_priority = '0;
  logic [31:0] result_action = '0;
  logic        contribution_end = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [4:0]  cfg_data = '0;
  logic        done;
  logic        out_kind;
  logic [31:0] pkt_id;
  logic        batch_closed;
  logic [2:0]  closed_batch;
  logic [31:0] merged_priority;
  logic [31:0] merged_action;
  logic        last_of_run;

  batched_result_min_reducer_unit uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .req_type(req_type),
    .batch_index(batch_index),
    .slot_index(slot_index),
    .result_priority(result_priority),
    .result_action(result_action),
    .contribution_end(contribution_end),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data),
    .done(done),
    .out_kind(out_kind),
    .pkt_id(pkt_id),
    .batch_closed(batch_closed),
    .closed_batch(closed_batch),
    .merged_priority(merged_priority),
    .merged_action(merged_action),
    .last_of_run(last_of_run)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // shadow of the batch ring
  logic [4:0]  eng_cnt = 5'd1;
  logic [31:0] id_next = '0;
  logic [2:0]  ring_ptr = '0;
  logic [4:0]  fill_cnt = '0;
  logic [31:0] slot_id   [RING][SLOTS];
  logic [31:0] slot_prio [RING][SLOTS];
  logic [31:0] slot_act  [RING][SLOTS];
  bit          prio_set  [RING][SLOTS] = '{default: '0};
  logic [4:0]  contrib_cnt [RING] = '{default: '0};
  logic [4:0]  valid_cnt   [RING] = '{default: '0};

  reduce_out_t owed_results[$];
  reduce_out_t head;
  int mismatches   = 0;
  int items_sent   = 0;
  int burst_left   = 0;
  int quiet_cycles = 0;

  function automatic reduce_req_t mk_req(logic [1:0] t, logic [2:0] b, logic [3:0] s,
                                         logic [31:0] p, logic [31:0] a, logic e);
    reduce_req_t r;
    r.rtype = t;
    r.bidx  = b;
    r.sidx  = s;
    r.prio  = p;
    r.act   = a;
    r.cend  = e;
    return r;
  endfunction

  function automatic logic [31:0] rand_prio();
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hFFFF_FFFF;
      2, 3: return $urandom_range(0, 3);  // ties are likely
      default: return $urandom;
    endcase
  endfunction

  // Steer result elements away from slot entries that were never written:
  // a non-first contribution must land on a written slot, and a publish must
  // only cover written slots.
  function automatic reduce_req_t make_safe(reduce_req_t r);
    int  i;
    int  j;
    int  cnt;
    bit  found;
    if (r.rtype != brmr_pkg::REQ_RESULT) return r;
    if (contrib_cnt[r.bidx] != 0 && !prio_set[r.bidx][r.sidx]) begin
      found = 1'b0;
      j = $urandom_range(0, SLOTS - 1);
      for (i = 0; i < SLOTS; i++)
        if (!found && prio_set[r.bidx][(i + j) % SLOTS]) begin
          r.sidx = 4'((i + j) % SLOTS);
          found = 1'b1;
        end
      if (!found) begin
        r.rtype = brmr_pkg::REQ_ARRIVAL;
        return r;
      end
    end
    if (r.cend) begin
      cnt = (contrib_cnt[r.bidx] < brmr_pkg::CNT_SAT) ? int'(contrib_cnt[r.bidx]) + 1 :
                                                         int'(contrib_cnt[r.bidx]);
      if (cnt == eng_cnt)
        for (i = 0; i < valid_cnt[r.bidx]; i++)
          if (!prio_set[r.bidx][i] && i != r.sidx) r.cend = 1'b0;
    end
    return r;
  endfunction

  // Apply one accepted request to the shadow ring and queue the results it owes.
  function automatic void reduce_step(reduce_req_t r);
    reduce_out_t o;
    logic [2:0]  b;
    int          i;
    o = '0;
    case (r.rtype)
      brmr_pkg::REQ_ARRIVAL, brmr_pkg::REQ_FLUSH: begin
        o.kind = brmr_pkg::OUT_ID;
        o.id   = id_next;
        if (r.rtype == brmr_pkg::REQ_ARRIVAL && fill_cnt < SLOTS) begin
          slot_id[ring_ptr][fill_cnt] = id_next;
          fill_cnt++;
        end
        if (r.rtype == brmr_pkg::REQ_FLUSH || fill_cnt >= SLOTS) begin
          o.closed = 1'b1;
          o.which  = ring_ptr;
          for (i = int'(fill_cnt); i < SLOTS; i++)
            slot_id[ring_ptr][i] = 32'hFFFF_FFFF;
          valid_cnt[ring_ptr]   = fill_cnt;
          contrib_cnt[ring_ptr] = '0;
          ring_ptr = (ring_ptr == RING - 1) ? 3'd0 : ring_ptr + 3'd1;
          fill_cnt = '0;
        end
        id_next++;
        owed_results = {owed_results, o};
      end
      brmr_pkg::REQ_RESULT: begin
        b = r.bidx;
        if (contrib_cnt[b] == 0 || r.prio < slot_prio[b][r.sidx]) begin
          slot_prio[b][r.sidx] = r.prio;
          slot_act[b][r.sidx]  = r.act;
          prio_set[b][r.sidx]  = 1'b1;
        end
        if (r.cend) begin
          if (contrib_cnt[b] < brmr_pkg::CNT_SAT) contrib_cnt[b]++;
          if (contrib_cnt[b] == eng_cnt)
            for (i = 0; i < valid_cnt[b]; i++) begin
              o      = '0;
              o.kind = brmr_pkg::OUT_PUBLISH;
              o.id   = slot_id[b][i];
              o.prio = slot_prio[b][i];
              o.act  = slot_act[b][i];
              o.last = (i + 1 == valid_cnt[b]);
              owed_results = {owed_results, o};
            end
        end
      end
      default: ;
    endcase
  endfunction

  task automatic send_req(input reduce_req_t raw);
    reduce_req_t r;
    int          gap;
    r = make_safe(raw);
    if (burst_left > 0) begin
      burst_left--;
      gap = 0;
    end else begin
      if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(8, 20);
      gap = $urandom_range(0, 4);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start            <= 1'b1;
    req_type         <= r.rtype;
    batch_index      <= r.bidx;
    slot_index       <= r.sidx;
    result_priority  <= r.prio;
    result_action    <= r.act;
    contribution_end <= r.cend;
    @(posedge clk);
    while (busy) @(posedge clk);
    reduce_step(r);
    if (r.rtype != REQ_UNUSED) items_sent++;
  endtask

  task automatic maybe_noise();
    if ($urandom_range(0, 9) == 0)
      send_req(mk_req(2'($urandom_range(0, 3)), 3'($urandom), 4'($urandom), $urandom,
                      $urandom, 1'($urandom_range(0, 1))));
  endtask

  // Wait until every owed result is in and the block has had time to go idle.
  task automatic settle();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_engine_count(input logic [4:0] n);
    settle();
    cfg_valid <= 1'b1;
    cfg_data  <= n;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    eng_cnt = n;
  endtask

  // Fill a batch, close it, then run one contribution per engine over it (two when the count is zero).
  task automatic run_batch_episode(input int max_fill);
    int b;
    int k;
    int nv;
    int rounds;
    int e;
    int i;
    b = int'(ring_ptr);
    k = ($urandom_range(0, 3) == 0) ? max_fill : $urandom_range(0, max_fill);
    for (i = 0; i < k && ring_ptr == b; i++) begin
      maybe_noise();
      send_req(mk_req(brmr_pkg::REQ_ARRIVAL, 3'($urandom), 4'($urandom), $urandom,
                      $urandom, 1'($urandom)));
    end
    if (ring_ptr == b)
      send_req(mk_req(brmr_pkg::REQ_FLUSH, 3'($urandom), 4'($urandom), $urandom,
                      $urandom, 1'($urandom)));
    nv = int'(valid_cnt[b]);
    rounds = (eng_cnt == 0) ? 2 : int'(eng_cnt);
    for (e = 0; e < rounds; e++) begin
      for (i = 0; i < nv; i++)
        if (e == 0 || $urandom_range(0, 2) == 0) begin
          maybe_noise();
          send_req(mk_req(brmr_pkg::REQ_RESULT, 3'(b), 4'(i), rand_prio(), $urandom, 1'b0));
        end
      send_req(mk_req(brmr_pkg::REQ_RESULT, 3'(b),
                      4'($urandom_range(0, (nv == 0) ? SLOTS - 1 : nv - 1)),
                      rand_prio(), $urandom, 1'b1));
    end
  endtask

  // engine count left at its reset value of one
  task automatic test_reset_engine_count();
    logic [2:0] b;
    b = ring_ptr;
    repeat (3) send_req(mk_req(brmr_pkg::REQ_ARRIVAL, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_FLUSH, '1, '1, '1, '1, 1'b1));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd0, 32'h0, 32'hFFFF_FFFF, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd1, 32'hFFFF_FFFF, 32'h0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd2, $urandom, $urandom, 1'b1));
  endtask

  task automatic test_empty_flush();
    logic [2:0] b;
    b = ring_ptr;
    send_req(mk_req(brmr_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd15, $urandom, $urandom, 1'b1));
  endtask

  task automatic test_unknown_request();
    send_req(mk_req(REQ_UNUSED, '1, '1, '1, '1, 1'b1));
    send_req(mk_req(REQ_UNUSED, '0, '0, '0, '0, 1'b0));
  endtask

  // two engines: lower priority wins, a tie keeps the earlier action
  task automatic test_min_merge();
    logic [2:0] b;
    write_engine_count(5'd2);
    b = ring_ptr;
    repeat (2) send_req(mk_req(brmr_pkg::REQ_ARRIVAL, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd0, 32'd100, 32'hA0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd1, 32'd50, 32'hA1, 1'b1));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd1, 32'd50, 32'hB1, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd0, 32'd99, 32'hB0, 1'b1));
  endtask

  task automatic test_engine_count_zero();
    logic [2:0] b;
    write_engine_count(5'd0);
    b = ring_ptr;
    send_req(mk_req(brmr_pkg::REQ_ARRIVAL, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0));
    repeat (3) send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd0, rand_prio(), $urandom, 1'b1));
  endtask

  // publishes on the 31st contribution and on every one after, as the count sticks at 31
  task automatic test_count_saturation();
    logic [2:0] b;
    write_engine_count(5'd31);
    b = ring_ptr;
    send_req(mk_req(brmr_pkg::REQ_ARRIVAL, '0, '0, '0, '0, 1'b0));
    send_req(mk_req(brmr_pkg::REQ_FLUSH, '0, '0, '0, '0, 1'b0));
    repeat (34) send_req(mk_req(brmr_pkg::REQ_RESULT, b, 4'd0, rand_prio(), $urandom, 1'b1));
  endtask

  task automatic test_random_traffic(input logic [4:0] n_eng, input int n_items,
                                     input int max_fill);
    int target;
    write_engine_count(n_eng);
    target = items_sent + n_items;
    while (items_sent < target) run_batch_episode(max_fill);
  endtask

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (owed_results.size() == 0) begin
        $display("%0t: result with none pending: kind %b id %h", $time, out_kind, pkt_id);
        mismatches++;
      end else begin
        head = owed_results.pop_front();
        check_field("out_kind", 32'(head.kind), 32'(out_kind));
        check_field("pkt_id", head.id, pkt_id);
        check_field("batch_closed", 32'(head.closed), 32'(batch_closed));
        check_field("closed_batch", 32'(head.which), 32'(closed_batch));
        check_field("merged_priority", head.prio, merged_priority);
        check_field("merged_action", head.act, merged_action);
        check_field("last_of_run", 32'(head.last), 32'(last_of_run));
      end
    end
  end

  // watchdog: cycles with no request, result or config write accepted
  always @(posedge clk) begin
    if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin
    rst <= 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_reset_engine_count();
    test_empty_flush();
    test_unknown_request();
    test_min_merge();
    test_random_traffic(5'd1, 100, 16);
    test_random_traffic(5'd2, 100, 16);
    test_random_traffic(5'd16, 60, 3);
    test_engine_count_zero();
    test_count_saturation();
    test_random_traffic(5'd3, 80, 8);
    settle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

// ===== sim.f =====
design/brmr_pkg.sv
design/batched_result_min_reducer_unit.sv
tb/tb_batched_result_min_reducer_unit.sv
